// ===== hdl/weight_change_stability_monitor_defines.svh =====
// Assertion macros for the weight change stability monitor checker.
// No dependencies; included by the checker file.
`ifndef WEIGHT_CHANGE_STABILITY_MONITOR_DEFINES_SVH
`define WEIGHT_CHANGE_STABILITY_MONITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WCSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wcsm assertion failed");

// Next-cycle implication, disabled during reset.
`define WCSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wcsm assertion failed");

`endif

// ===== hdl/wcsm_pkg.sv =====
// Package for the weight change stability monitor: widths, codes and item types.
// No dependencies; used by every module of the block.
`default_nettype none

package wcsm_pkg;

    localparam int WEIGHT_WIDTH = 24;
    localparam int TOL_WIDTH    = 24;
    localparam int CONF_WIDTH   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CMP_W        = (WEIGHT_WIDTH > TOL_WIDTH) ? WEIGHT_WIDTH : TOL_WIDTH;

    localparam logic [CONF_WIDTH-1:0] SETTLE_MAX = CONF_WIDTH'(60000);

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THR   = 2'd2;

    typedef logic [CMP_W-1:0] cmp_t;
    typedef logic signed [WEIGHT_WIDTH:0] delta_t;

    typedef struct packed {
        logic signed [WEIGHT_WIDTH-1:0] weight_sample;
        logic                           sign_flag;
        logic                           cell_error;
    } in_item_t;

    typedef struct packed {
        logic signed [WEIGHT_WIDTH:0]   weight_delta;
        logic [WEIGHT_WIDTH-1:0]        abs_delta;
        logic [1:0]                     direction;
        logic                           first_update;
        logic                           sign_changed;
        logic                           error_seen;
        logic                           jump_detected;
        logic                           stable_event;
        logic                           unstable_event;
    } out_item_t;

    typedef struct packed {
        logic [TOL_WIDTH-1:0]  settle_band;
        logic [CONF_WIDTH-1:0] confirm_count;
        logic [TOL_WIDTH-1:0]  jump_threshold;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/weight_change_stability_monitor.sv =====
// Weight change stability monitor: one result item per accepted weight item.
// The result is computed combinationally and registered in the output buffer.
// Throughput: one item per cycle unless both buffer entries are full; the two-entry
// output buffer keeps input open for one more item while a result waits.
// Reset clears history (next item is the baseline), the settle count, the output
// buffer, and the registers to tolerance 0, confirm 1, jump threshold 0.
`default_nettype none

module weight_change_stability_monitor
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire wcsm_pkg::in_item_t                in_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output wcsm_pkg::out_item_t                    out_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wcsm_pkg::TOL_WIDTH-1:0]    cfg_data
);

    wcsm_pkg::cfg_t         cfg;
    wcsm_pkg::out_item_t    result;
    logic                   accept;

    assign accept = in_valid && in_ready;

    wcsm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wcsm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_item (in_item),
        .cfg     (cfg),
        .result  (result)
    );

    wcsm_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .space     (in_ready),
        .push_item (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== hdl/wcsm_cfg.sv =====
// Configuration register file of the weight change stability monitor.
// Depends on wcsm_pkg.
`default_nettype none

module wcsm_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wcsm_pkg::TOL_WIDTH-1:0]    cfg_data,
    output wcsm_pkg::cfg_t                         cfg
);

    wcsm_pkg::cfg_t cfg_reg;
    wcsm_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                wcsm_pkg::CFG_STABLE_TOL: cfg_next.settle_band = cfg_data;
                wcsm_pkg::CFG_CONFIRM:
                    cfg_next.confirm_count = cfg_data[wcsm_pkg::CONF_WIDTH-1:0];
                wcsm_pkg::CFG_JUMP_THR:   cfg_next.jump_threshold = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_band    <= '0;
            cfg_reg.confirm_count  <= wcsm_pkg::CONF_WIDTH'(1);
            cfg_reg.jump_threshold <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wcsm_core.sv =====
// Per-item delta, flag and settle-count logic with the sample history state.
// Depends on wcsm_pkg.
`default_nettype none

module wcsm_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire wcsm_pkg::in_item_t   in_item,
    input  wire wcsm_pkg::cfg_t       cfg,
    output wcsm_pkg::out_item_t       result
);

    localparam int W = wcsm_pkg::WEIGHT_WIDTH;

    logic signed [W-1:0]              last_weight_reg;
    logic signed [W-1:0]              last_weight_next;
    logic                             last_sign_reg;
    logic                             last_sign_next;
    logic                             awaiting_first_reg;
    logic                             awaiting_first_next;
    logic [wcsm_pkg::CONF_WIDTH-1:0]  settle_count_reg;
    logic [wcsm_pkg::CONF_WIDTH-1:0]  settle_count_next;

    wcsm_pkg::delta_t                 delta;
    wcsm_pkg::delta_t                 magnitude;
    logic [W-1:0]                     abs_d;
    wcsm_pkg::cmp_t                   abs_ext;
    logic                             settled;
    logic [wcsm_pkg::CONF_WIDTH-1:0]  count_inc;

    assign delta     = {in_item.weight_sample[W-1], in_item.weight_sample}
                     - {last_weight_reg[W-1], last_weight_reg};
    assign magnitude = delta[W] ? -delta : delta;
    assign abs_d     = magnitude[W-1:0];
    assign abs_ext   = wcsm_pkg::cmp_t'(abs_d);
    assign settled   = abs_ext <= wcsm_pkg::cmp_t'(cfg.settle_band);
    assign count_inc = (settle_count_reg < wcsm_pkg::SETTLE_MAX)
                     ? settle_count_reg + 1'b1 : settle_count_reg;

    always_comb
    begin
        result              = '0;
        result.error_seen   = in_item.cell_error;
        settle_count_next   = settle_count_reg;
        if (awaiting_first_reg)
        begin
            result.first_update = 1'b1;
            settle_count_next   = '0;
        end
        else
        begin
            result.weight_delta  = delta;
            result.abs_delta     = abs_d;
            result.direction     = delta[W] ? wcsm_pkg::DIR_DOWN
                                 : (delta != '0) ? wcsm_pkg::DIR_UP : wcsm_pkg::DIR_NONE;
            result.sign_changed  = in_item.sign_flag != last_sign_reg;
            result.jump_detected = (cfg.jump_threshold != '0)
                                 && (abs_ext > wcsm_pkg::cmp_t'(cfg.jump_threshold));
            if (settled)
            begin
                settle_count_next   = count_inc;
                result.stable_event = count_inc >= cfg.confirm_count;
            end
            else
            begin
                settle_count_next     = '0;
                result.unstable_event = 1'b1;
            end
        end
    end

    assign last_weight_next    = accept ? in_item.weight_sample : last_weight_reg;
    assign last_sign_next      = accept ? in_item.sign_flag : last_sign_reg;
    assign awaiting_first_next = accept ? 1'b0 : awaiting_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_weight_reg    <= '0;
            last_sign_reg      <= 1'b0;
            awaiting_first_reg <= 1'b1;
            settle_count_reg   <= '0;
        end
        else
        begin
            last_weight_reg    <= last_weight_next;
            last_sign_reg      <= last_sign_next;
            awaiting_first_reg <= awaiting_first_next;
            if (accept)
            begin
                settle_count_reg <= settle_count_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wcsm_outbuf.sv =====
// Two-entry output buffer: result register plus skid register.
// Depends on wcsm_pkg.
`default_nettype none

module wcsm_outbuf
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      space,
    input  wire wcsm_pkg::out_item_t  push_item,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wcsm_pkg::out_item_t       out_item
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    wcsm_pkg::out_item_t    out_data_reg;
    wcsm_pkg::out_item_t    out_data_next;
    wcsm_pkg::out_item_t    skid_data_reg;
    wcsm_pkg::out_item_t    skid_data_next;
    logic                   pop;

    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_data_next = push_item;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = push_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_item;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/wcsm_checker.sv =====
// Port-level assertions for the weight change stability monitor, bound to the top.
// Depends on wcsm_pkg and weight_change_stability_monitor_defines.svh.
`default_nettype none
`include "weight_change_stability_monitor_defines.svh"

module wcsm_checker
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_ready,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire wcsm_pkg::out_item_t  out_item
);

    `WCSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_item))

    `WCSM_ASSERT_NOW(a_full_has_out, clk, rst_n, !in_ready, out_valid)

    `WCSM_ASSERT_NOW(a_baseline_quiet, clk, rst_n, out_valid && out_item.first_update,
        out_item.weight_delta == '0 && out_item.direction == wcsm_pkg::DIR_NONE
        && !out_item.stable_event && !out_item.unstable_event && !out_item.jump_detected)

    `WCSM_ASSERT_NOW(a_dir_match, clk, rst_n, out_valid,
        (out_item.direction == wcsm_pkg::DIR_NONE) == (out_item.abs_delta == '0)
        && !(out_item.stable_event && out_item.unstable_event))

endmodule

bind weight_change_stability_monitor wcsm_checker u_wcsm_checker (.*);

`default_nettype wire

// ===== bench/tb_weight_change_stability_monitor.sv =====
// Self-checking bench for the weight change stability monitor: directed and random samples,
// register writes between phases, and random idling on input and result channels.
// Depends on wcsm_pkg and the weight_change_stability_monitor RTL.
module tb_weight_change_stability_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PRINT_LIMIT = 50;
    localparam logic [wcsm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    wcsm_pkg::in_item_t                  in_item   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    wcsm_pkg::out_item_t                 out_item;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [wcsm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [wcsm_pkg::TOL_WIDTH-1:0]      cfg_data  = '0;

    // predictor state and register copies
    logic signed [wcsm_pkg::WEIGHT_WIDTH-1:0] prev_weight   = '0;
    logic                                     prev_sign     = 1'b0;
    logic                                     awaiting_base = 1'b1;
    logic [wcsm_pkg::CONF_WIDTH-1:0]          settle_cnt    = '0;
    logic [wcsm_pkg::TOL_WIDTH-1:0]           tol_reg       = '0;
    logic [wcsm_pkg::CONF_WIDTH-1:0]          confirm_reg   = wcsm_pkg::CONF_WIDTH'(1);
    logic [wcsm_pkg::TOL_WIDTH-1:0]           jump_reg      = '0;

    wcsm_pkg::out_item_t pending_changes[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt    = 0;
    int        idle_pct     = 0;
    int        stall_pct    = 0;

    weight_change_stability_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic wcsm_pkg::out_item_t predict_change(input wcsm_pkg::in_item_t it);
        wcsm_pkg::out_item_t r;
        wcsm_pkg::delta_t d;
        logic [wcsm_pkg::WEIGHT_WIDTH:0] mag;
        r = '0;
        r.error_seen = it.cell_error;
        if (awaiting_base)
        begin
            awaiting_base = 1'b0;
            settle_cnt = '0;
            r.first_update = 1'b1;
        end
        else
        begin
            d = wcsm_pkg::delta_t'(it.weight_sample) - wcsm_pkg::delta_t'(prev_weight);
            mag = (d < 0) ? -d : d;
            r.weight_delta = d;
            r.abs_delta = mag[wcsm_pkg::WEIGHT_WIDTH-1:0];
            if (d < 0)
                r.direction = wcsm_pkg::DIR_DOWN;
            else if (d > 0)
                r.direction = wcsm_pkg::DIR_UP;
            else
                r.direction = wcsm_pkg::DIR_NONE;
            r.sign_changed = (it.sign_flag != prev_sign);
            r.jump_detected = (jump_reg != '0) && (r.abs_delta > jump_reg);
            if (r.abs_delta <= tol_reg)
            begin
                if (settle_cnt < wcsm_pkg::SETTLE_MAX)
                    settle_cnt = settle_cnt + 1'b1;
                r.stable_event = (settle_cnt >= confirm_reg);
            end
            else
            begin
                settle_cnt = '0;
                r.unstable_event = 1'b1;
            end
        end
        prev_weight = it.weight_sample;
        prev_sign = it.sign_flag;
        return r;
    endfunction

    always @(posedge clk)
    begin : check_results
        wcsm_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_changes.size() == 0)
                report_mismatch("result item with nothing pending");
            else
            begin
                want = pending_changes.pop_front();
                check_field("weight_delta", out_item.weight_delta, want.weight_delta);
                check_field("abs_delta", out_item.abs_delta, want.abs_delta);
                check_field("direction", out_item.direction, want.direction);
                check_field("first_update", out_item.first_update, want.first_update);
                check_field("sign_changed", out_item.sign_changed, want.sign_changed);
                check_field("error_seen", out_item.error_seen, want.error_seen);
                check_field("jump_detected", out_item.jump_detected, want.jump_detected);
                check_field("stable_event", out_item.stable_event, want.stable_event);
                check_field("unstable_event", out_item.unstable_event, want.unstable_event);
            end
        end
    end

    function automatic wcsm_pkg::in_item_t mk_sample(input int w, input bit s, input bit e);
        wcsm_pkg::in_item_t it;
        it.weight_sample = wcsm_pkg::WEIGHT_WIDTH'(w);
        it.sign_flag = s;
        it.cell_error = e;
        return it;
    endfunction

    // mostly small moves around the last weight, plus tolerance and threshold edges and some fully random weights
    function automatic wcsm_pkg::in_item_t random_sample();
        wcsm_pkg::in_item_t it;
        int r;
        int k;
        int b;
        logic signed [31:0] w;
        r = $urandom_range(99);
        k = (tol_reg > 2000) ? 2002 : int'(tol_reg) + 2;
        w = prev_weight;
        if (r < 55)
            w = w + int'($urandom_range(2 * k)) - k;
        else if (r < 80)
        begin
            b = (r < 70) ? int'(tol_reg) : int'(jump_reg);
            b = b + int'($urandom_range(1));
            w = $urandom_range(1) ? w + b : w - b;
        end
        else
            w = $urandom();
        it.weight_sample = w[wcsm_pkg::WEIGHT_WIDTH-1:0];
        it.sign_flag = ($urandom_range(99) < 20) ? ~prev_sign : prev_sign;
        it.cell_error = ($urandom_range(99) < 10);
        return it;
    endfunction

    function automatic logic [wcsm_pkg::TOL_WIDTH-1:0] random_limit();
        case ($urandom_range(4))
            0: return '0;
            1: return '1;
            2: return wcsm_pkg::TOL_WIDTH'($urandom_range(1, 16));
            3: return wcsm_pkg::TOL_WIDTH'($urandom_range(17, 4000));
            default: return wcsm_pkg::TOL_WIDTH'($urandom());
        endcase
    endfunction

    // upper data bits are random; only the low 16 bits land in the register
    function automatic logic [wcsm_pkg::TOL_WIDTH-1:0] random_confirm();
        logic [wcsm_pkg::CONF_WIDTH-1:0] c;
        case ($urandom_range(4))
            0: c = '0;
            1: c = wcsm_pkg::CONF_WIDTH'(1);
            2, 3: c = wcsm_pkg::CONF_WIDTH'($urandom_range(2, 8));
            default: c = wcsm_pkg::CONF_WIDTH'($urandom_range(60000, 65535));
        endcase
        return {8'($urandom()), c};
    endfunction

    task automatic set_idle(input int snd, input int rcv);
        idle_pct = snd;
        stall_pct = rcv;
    endtask

    task automatic send_sample(input wcsm_pkg::in_item_t it);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (!in_ready);
        pending_changes.push_back(predict_change(it));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_changes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [wcsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wcsm_pkg::TOL_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            wcsm_pkg::CFG_STABLE_TOL: tol_reg = data;
            wcsm_pkg::CFG_CONFIRM:    confirm_reg = data[wcsm_pkg::CONF_WIDTH-1:0];
            wcsm_pkg::CFG_JUMP_THR:   jump_reg = data;
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [wcsm_pkg::TOL_WIDTH-1:0] tol,
                                input logic [wcsm_pkg::TOL_WIDTH-1:0] conf,
                                input logic [wcsm_pkg::TOL_WIDTH-1:0] jthr);
        drain_results();
        write_reg(wcsm_pkg::CFG_STABLE_TOL, tol);
        write_reg(wcsm_pkg::CFG_CONFIRM, conf);
        write_reg(wcsm_pkg::CFG_JUMP_THR, jthr);
        cfg_valid <= 1'b0;
    endtask

    // reset registers: baseline item, then zero and unit changes
    task automatic test_baseline_defaults();
        send_sample(mk_sample(100, 1'b1, 1'b1));
        send_sample(mk_sample(100, 1'b1, 1'b0));
        send_sample(mk_sample(101, 1'b0, 1'b0));
        send_sample(mk_sample(101, 1'b0, 1'b1));
    endtask

    task automatic test_weight_extremes();
        apply_config(wcsm_pkg::TOL_WIDTH'(5), wcsm_pkg::TOL_WIDTH'(2),
                     wcsm_pkg::TOL_WIDTH'(16777214));
        send_sample(mk_sample(8388607, 1'b0, 1'b0));
        send_sample(mk_sample(-8388608, 1'b1, 1'b0));
        send_sample(mk_sample(8388607, 1'b1, 1'b1));
        send_sample(mk_sample(8388602, 1'b1, 1'b0));
        send_sample(mk_sample(8388602, 1'b0, 1'b0));
        send_sample(mk_sample(-1, 1'b0, 1'b0));
        send_sample(mk_sample(0, 1'b0, 1'b0));
    endtask

    // zero confirm count with full tolerance, then the narrowest jump limit
    task automatic test_config_extremes();
        apply_config('1, '0, '1);
        send_sample(mk_sample(0, 1'b0, 1'b0));
        send_sample(mk_sample(-8388608, 1'b1, 1'b1));
        send_sample(mk_sample(8388607, 1'b0, 1'b0));
        apply_config('0, wcsm_pkg::TOL_WIDTH'(65535), wcsm_pkg::TOL_WIDTH'(1));
        send_sample(mk_sample(8388607, 1'b0, 1'b0));
        send_sample(mk_sample(8388606, 1'b0, 1'b0));
        send_sample(mk_sample(8388604, 1'b1, 1'b0));
    endtask

    // out-of-range index is dropped; confirm keeps only its low bits
    task automatic test_register_index();
        drain_results();
        write_reg(CFG_UNUSED, '1);
        write_reg(wcsm_pkg::CFG_CONFIRM, wcsm_pkg::TOL_WIDTH'(24'hFF0002));
        cfg_valid <= 1'b0;
        send_sample(mk_sample(8388604, 1'b1, 1'b0));
        send_sample(mk_sample(8388604, 1'b1, 1'b0));
        send_sample(mk_sample(8388604, 1'b1, 1'b0));
    endtask

    // settle count climbs under a confirm count at the settle ceiling and one above it
    task automatic test_settle_saturation();
        set_idle(0, 0);
        apply_config('1, wcsm_pkg::TOL_WIDTH'(60000), '0);
        repeat (40) send_sample(mk_sample($urandom(), $urandom_range(1), $urandom_range(1)));
        apply_config('1, wcsm_pkg::TOL_WIDTH'(60001), '0);
        repeat (6) send_sample(mk_sample($urandom(), $urandom_range(1), $urandom_range(1)));
    endtask

    task automatic test_random_phases();
        int snd_modes[4];
        int rcv_modes[4];
        snd_modes = '{0, 73, 0, 22};
        rcv_modes = '{0, 0, 73, 22};
        for (int p = 0; p < 12; p++)
        begin
            set_idle(snd_modes[p % 4], rcv_modes[p % 4]);
            apply_config(random_limit(), random_confirm(), random_limit());
            repeat (100) send_sample(random_sample());
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idle(22, 22);
        test_baseline_defaults();
        test_weight_extremes();
        test_config_extremes();
        test_register_index();
        test_settle_saturation();
        test_random_phases();
        in_valid <= 1'b0;
        for (int w = 0; w < 10000 && pending_changes.size() != 0; w++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_changes.size() != 0)
            report_mismatch($sformatf("%0d expected results never came",
                                      pending_changes.size()));
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
